>>> sv/lcbs_pkg.sv
// Package for the LED chase-then-blink sequencer: field widths, reset values,
// register indexes, result stage codes and wrap-aware millisecond helpers.
// No dependencies.
package lcbs_pkg;

  // Default number of LED outputs that the mask can drive
  localparam int unsigned MAX_LEDS_DEF = 16;

  // Field widths
  localparam int unsigned LED_COUNT_W = 5;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned DUR_W       = 31;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LED_MASK_W  = 16;
  localparam int unsigned STAGE_W     = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned S_TDATA_W   = 32;  // show length padded to bytes
  localparam int unsigned M_TDATA_W   = 24;  // led_mask, show_stage padded to bytes

  // Register reset values
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 5'd1;
  localparam logic [PERIOD_W-1:0]    CHASE_RST     = 16'd70;
  localparam logic [PERIOD_W-1:0]    BLINK_RST     = 16'd500;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_COUNT  = 2'd0,
    REG_CHASE_STEP = 2'd1,
    REG_BLINK_HALF = 2'd2
  } cfg_reg_e;

  // Operation carried in tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Stage code reported with each result
  typedef enum logic [STAGE_W-1:0] {
    STG_IDLE  = 2'd0,
    STG_CHASE = 2'd1,
    STG_BLINK = 2'd2,
    STG_DONE  = 2'd3
  } stage_e;

  typedef logic [TIME_W-1:0] ms_t;

  // True when a lies before b, comparing the signed 32-bit difference
  function automatic logic is_before(ms_t a, ms_t b);
    ms_t d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

  // Due time for an event at 'when': never sooner than one tick after 'base'
  function automatic ms_t plan_at(ms_t when, ms_t base);
    ms_t d;
    d = when - base;
    if ((d == '0) || d[TIME_W-1]) begin
      return base + ms_t'(1);
    end else begin
      return when;
    end
  endfunction

endpackage

>>> sv/led_chase_then_blink_sequencer.sv
// LED chase-then-blink sequencer: show state, per-item update and output queue.
// Depends on lcbs_pkg.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the item kind, 0 = one millisecond
//   tick, 1 = start a show; tdata carries the show length in ms (start only).
//   Every accepted item yields exactly one result on the output stream
//   (m_axis_*): the LED mask after the item and the stage of the show.
//   Configuration: cfg_we_i writes register cfg_index_i (0 LED count,
//   1 chase step ms, 2 blink half period ms) from cfg_wdata_i.
// Timing:
//   One item per cycle while s_axis_tready is high. Each result is registered
//   into the output queue when its item is accepted. Results go through a
//   two-entry output queue, so an item is still taken while one result waits;
//   s_axis_tready drops when both entries are full. After a write of the LED
//   count, the successor of the chase position is recomputed by a bit-serial
//   remainder unit, which holds s_axis_tready low while it runs.
// Reset:
//   Show idle, all LEDs off, millisecond counter zero, registers at their
//   defaults (1 LED, 70 ms chase step, 500 ms blink half period), queue empty.
module led_chase_then_blink_sequencer
  import lcbs_pkg::*;
#(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [30:0] show length in ms, [31] zero
  input  logic                  s_axis_tuser,   // [0] operation
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata    // [15:0] led_mask, [17:16] show_stage
);

  // Width of an LED count up to MAX_LEDS, and of an LED position
  localparam int unsigned EW  = $clog2(MAX_LEDS + 1);
  localparam int unsigned PW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned DCW = $clog2(EW + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHASE,
    PH_BLINK,
    PH_END,
    PH_DONE
  } phase_e;

  typedef logic [MAX_LEDS-1:0] leds_t;

  // Next chase position for a position below the count
  function automatic logic [PW-1:0] succ_of(logic [PW-1:0] p, logic [EW-1:0] n);
    logic [EW-1:0] nx;
    nx = EW'(p) + EW'(1);
    if ((n == '0) || (nx >= n)) begin
      return '0;
    end else begin
      return PW'(nx);
    end
  endfunction

  function automatic stage_e stage_of(phase_e ph);
    stage_e s;
    unique case (ph)
      PH_CHASE:        s = STG_CHASE;
      PH_BLINK,
      PH_END:          s = STG_BLINK;
      PH_DONE:         s = STG_DONE;
      default:         s = STG_IDLE;
    endcase
    return s;
  endfunction

  // Configuration registers
  logic [LED_COUNT_W-1:0] count_q;
  logic [PERIOD_W-1:0]    chase_q;
  logic [PERIOD_W-1:0]    blink_q;

  // Show state
  phase_e        phase_q, phase_d;
  ms_t           elapsed_q, elapsed_d;
  ms_t           due_q, due_d;
  ms_t           mark_q, mark_d;
  ms_t           half_q, half_d;
  ms_t           end_q, end_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] succ_q, succ_d;
  logic          blink_lit_q, blink_lit_d;
  leds_t         mask_q, mask_d;

  // Remainder unit for (pos + 1) mod count
  logic           div_load_q;
  logic [DCW-1:0] div_cnt_q;
  logic [EW-1:0]  div_x_q;
  logic [EW-1:0]  div_rem_q;
  logic [EW:0]    div_sh;
  logic [EW-1:0]  div_rem_nx;
  logic           busy;

  // Output queue
  logic [1:0]           cnt_q;
  logic [M_TDATA_W-1:0] slot0_q, slot1_q;
  logic [M_TDATA_W-1:0] res;
  logic                 push, pop;

  // Per-item signals
  logic [EW-1:0]  eff;
  leds_t          all_leds;
  logic [DUR_W-1:0] dur;
  ms_t            el_inc, chase_src, chase_mark, blink_mark, half_new, end_new;
  logic           fire;

  // Effective LED count, clamped to the mask width
  always_comb begin
    if (TIME_W'(count_q) < TIME_W'(MAX_LEDS)) begin
      eff = EW'(count_q);
    end else begin
      eff = EW'(MAX_LEDS);
    end
  end

  // LEDs in use
  always_comb begin
    for (int i = 0; i < MAX_LEDS; i++) begin
      all_leds[i] = (EW'(i) < eff);
    end
  end

  // Handshakes
  assign busy          = div_load_q || (div_cnt_q != '0);
  assign s_axis_tready = (cnt_q != 2'd2) && !busy;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = slot0_q;

  assign dur = s_axis_tdata[DUR_W-1:0];

  // Item update: one tick or one start
  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    due_d       = due_q;
    mark_d      = mark_q;
    half_d      = half_q;
    end_d       = end_q;
    pos_d       = pos_q;
    succ_d      = succ_q;
    blink_lit_d = blink_lit_q;
    mask_d      = mask_q;

    el_inc     = elapsed_q + ms_t'(1);
    fire       = ((phase_q == PH_CHASE) || (phase_q == PH_BLINK) || (phase_q == PH_END))
                 && !is_before(el_inc, due_q);
    chase_src  = (s_axis_tuser == OP_START) ? elapsed_q : mark_q;
    chase_mark = chase_src + ms_t'(chase_q);
    blink_mark = mark_q + ms_t'(blink_q);
    half_new   = elapsed_q + ms_t'(dur >> 1);
    end_new    = elapsed_q + ms_t'(dur);

    if (push) begin
      if (s_axis_tuser == OP_TICK) begin
        elapsed_d = el_inc;
        if (fire) begin
          unique case (phase_q)
            PH_CHASE: begin
              // move the lit LED, then chase on or hand over to the blink
              mask_d = (mask_q & ~(leds_t'(1) << pos_q)) | (leds_t'(1) << succ_q);
              pos_d  = succ_q;
              succ_d = succ_of(succ_q, eff);
              mark_d = chase_mark;
              if (is_before(chase_mark, half_q)) begin
                phase_d = PH_CHASE;
                due_d   = plan_at(chase_mark, el_inc);
              end else begin
                phase_d     = PH_BLINK;
                blink_lit_d = 1'b0;
                due_d       = plan_at(half_q, el_inc);
              end
            end
            PH_BLINK: begin
              blink_lit_d = !blink_lit_q;
              mask_d      = blink_lit_q ? (mask_q & ~all_leds) : (mask_q | all_leds);
              mark_d      = blink_mark;
              if (is_before(blink_mark, end_q)) begin
                phase_d = PH_BLINK;
                due_d   = plan_at(blink_mark, el_inc);
              end else begin
                phase_d = PH_END;
                due_d   = plan_at(end_q, el_inc);
              end
            end
            PH_END: begin
              mask_d  = mask_q & ~all_leds;
              phase_d = PH_DONE;
            end
            default: begin
            end
          endcase
        end
      end else begin
        // start: cancel anything pending, begin a new show if LEDs are in use
        phase_d = PH_IDLE;
        if (eff != '0) begin
          pos_d  = '0;
          succ_d = succ_of('0, eff);
          mark_d = chase_mark;
          half_d = half_new;
          end_d  = end_new;
          mask_d = (mask_q & ~all_leds) | leds_t'(1);
          if (is_before(chase_mark, half_new)) begin
            phase_d = PH_CHASE;
            due_d   = plan_at(chase_mark, elapsed_q);
          end else begin
            phase_d     = PH_BLINK;
            blink_lit_d = 1'b0;
            due_d       = plan_at(half_new, elapsed_q);
          end
        end
      end
    end
  end

  // Result of this item
  assign res = M_TDATA_W'({stage_of(phase_d), LED_MASK_W'(mask_d)});

  // One restoring step of the remainder unit
  always_comb begin
    div_sh = {div_rem_q, div_x_q[EW-1]};
    if (div_sh >= {1'b0, eff}) begin
      div_rem_nx = EW'(div_sh - {1'b0, eff});
    end else begin
      div_rem_nx = EW'(div_sh);
    end
  end

  // Control and show state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= LED_COUNT_RST;
      chase_q     <= CHASE_RST;
      blink_q     <= BLINK_RST;
      phase_q     <= PH_IDLE;
      elapsed_q   <= '0;
      due_q       <= '0;
      mark_q      <= '0;
      half_q      <= '0;
      end_q       <= '0;
      pos_q       <= '0;
      succ_q      <= '0;
      blink_lit_q <= 1'b0;
      mask_q      <= '0;
      div_load_q  <= 1'b0;
      div_cnt_q   <= '0;
      cnt_q       <= 2'd0;
    end else begin
      // configuration writes; an LED count write restarts the remainder unit
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LED_COUNT:  count_q <= cfg_wdata_i[LED_COUNT_W-1:0];
          REG_CHASE_STEP: chase_q <= cfg_wdata_i[PERIOD_W-1:0];
          REG_BLINK_HALF: blink_q <= cfg_wdata_i[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end

      if (cfg_we_i && (cfg_index_i == REG_LED_COUNT)) begin
        div_load_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_load_q) begin
        div_load_q <= 1'b0;
        div_cnt_q  <= DCW'(EW);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end

      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      due_q       <= due_d;
      mark_q      <= mark_d;
      half_q      <= half_d;
      end_q       <= end_d;
      pos_q       <= pos_d;
      blink_lit_q <= blink_lit_d;
      mask_q      <= mask_d;

      // successor: from the remainder unit on its last step, else from the item
      if (!div_load_q && (div_cnt_q == DCW'(1))) begin
        succ_q <= (eff == '0) ? '0 : PW'(div_rem_nx);
      end else begin
        succ_q <= succ_d;
      end

      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  // Remainder unit data path
  always_ff @(posedge clk_i) begin
    if (div_load_q) begin
      div_x_q   <= EW'(pos_q) + EW'(1);
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_x_q   <= div_x_q << 1;
      div_rem_q <= div_rem_nx;
    end
  end

  // Output queue entries, head in slot 0
  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
      slot0_q <= res;
    end else if (pop && (cnt_q == 2'd2)) begin
      slot0_q <= slot1_q;
    end
    if (push && (cnt_q == 2'd1) && !pop) begin
      slot1_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // A pending event is always due strictly after the current millisecond
  a_due_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_CHASE) || (phase_q == PH_BLINK) || (phase_q == PH_END))
    |-> ((due_q != elapsed_q) && !is_before(due_q, elapsed_q)))
    else $error("pending event not ahead of the millisecond counter");

  // Stored successor matches the position once the remainder unit is done, if the position is below the count
  a_succ_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && ((eff == '0) || (EW'(pos_q) < eff)))
    |-> (succ_q == succ_of(pos_q, eff)))
    else $error("chase successor out of step with position");

  // During the chase the LED at the current position is lit
  a_chase_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CHASE) |-> mask_q[pos_q])
    else $error("chase position LED not lit");
`endif

endmodule

>>> test/tb_led_chase_then_blink_sequencer.sv
// Testbench for led_chase_then_blink_sequencer: stream stimulus, a scoreboard
// with its own model of the LED show, pacing on both sides and an output hold-off.
// Depends on lcbs_pkg and the sequencer RTL.
module tb_led_chase_then_blink_sequencer;
  import lcbs_pkg::*;

  localparam int unsigned        HOLD_OFF_CYCLES = 60;
  localparam int unsigned        STALL_LIMIT     = 1000;
  localparam int unsigned        ROUND_ITEMS     = 53;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;  // unmapped index

  // Show phase of the predictor
  typedef enum logic [2:0] {
    SHOW_IDLE,
    SHOW_CHASE,
    SHOW_BLINK,
    SHOW_END,
    SHOW_DONE
  } show_phase_e;

  typedef struct packed {
    logic [LED_MASK_W-1:0] mask;
    stage_e                stage;
  } led_result_t;

  // Scoreboard: predicts the LED state for every accepted item
  class led_show_scoreboard;
    logic [LED_COUNT_W-1:0] led_count_q;
    logic [PERIOD_W-1:0]    chase_ms;
    logic [PERIOD_W-1:0]    blink_ms;
    show_phase_e            show_phase;
    ms_t                    now_ms;
    ms_t                    due_ms;
    ms_t                    mark_ms;
    ms_t                    half_ms;
    ms_t                    end_ms;
    logic [3:0]             pos;
    logic                   blink_on;
    logic [LED_MASK_W-1:0]  lit;
    led_result_t            expected_q[$];
    int unsigned            errors;
    int unsigned            checked;

    function new();
      led_count_q = LED_COUNT_RST;
      chase_ms    = CHASE_RST;
      blink_ms    = BLINK_RST;
      show_phase  = SHOW_IDLE;
      now_ms      = '0;
      due_ms      = '0;
      mark_ms     = '0;
      half_ms     = '0;
      end_ms      = '0;
      pos         = '0;
      blink_on    = 1'b0;
      lit         = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LED_COUNT:  led_count_q = val[LED_COUNT_W-1:0];
        REG_CHASE_STEP: chase_ms = val;
        REG_BLINK_HALF: blink_ms = val;
        default: ;
      endcase
    endfunction

    function int unsigned active_leds();
      return (led_count_q > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(led_count_q);
    endfunction

    // next event never lands before the next tick
    function void schedule(ms_t when);
      ms_t ahead;
      ahead = when - now_ms;
      if (ahead == '0 || ahead[TIME_W-1]) begin
        due_ms = now_ms + 1;
      end else begin
        due_ms = when;
      end
    endfunction

    function void switch_all(logic on);
      int unsigned n;
      logic [LED_MASK_W-1:0] span;
      n = active_leds();
      span = (n >= LED_MASK_W) ? '1 : LED_MASK_W'((32'd1 << n) - 1);
      lit = on ? (lit | span) : (lit & ~span);
    endfunction

    function void next_chase();
      ms_t gap;
      mark_ms += ms_t'(chase_ms);
      gap = mark_ms - half_ms;
      if (gap[TIME_W-1]) begin
        show_phase = SHOW_CHASE;
        schedule(mark_ms);
      end else begin
        show_phase = SHOW_BLINK;
        blink_on = 1'b0;
        schedule(half_ms);
      end
    endfunction

    function void next_blink();
      ms_t gap;
      mark_ms += ms_t'(blink_ms);
      gap = mark_ms - end_ms;
      if (gap[TIME_W-1]) begin
        show_phase = SHOW_BLINK;
        schedule(mark_ms);
      end else begin
        show_phase = SHOW_END;
        schedule(end_ms);
      end
    endfunction

    function void fire();
      int unsigned n;
      n = active_leds();
      case (show_phase)
        SHOW_CHASE: begin
          lit[pos] = 1'b0;
          pos = (n == 0) ? 4'd0 : 4'((int'(pos) + 1) % n);
          lit[pos] = 1'b1;
          next_chase();
        end
        SHOW_BLINK: begin
          blink_on = ~blink_on;
          switch_all(blink_on);
          next_blink();
        end
        SHOW_END: begin
          switch_all(1'b0);
          show_phase = SHOW_DONE;
        end
        default: ;
      endcase
    endfunction

    // Accepted input item: advance the model and queue the expected result
    function void note_item(logic op, logic [DUR_W-1:0] dur);
      ms_t         late;
      led_result_t want;
      if (op == OP_TICK) begin
        now_ms += 1;
        late = now_ms - due_ms;
        if ((show_phase == SHOW_CHASE || show_phase == SHOW_BLINK ||
             show_phase == SHOW_END) && !late[TIME_W-1]) begin
          fire();
        end
      end else begin
        show_phase = SHOW_IDLE;
        if (active_leds() != 0) begin
          pos     = '0;
          mark_ms = now_ms;
          half_ms = now_ms + ms_t'(dur >> 1);
          end_ms  = now_ms + ms_t'(dur);
          switch_all(1'b0);
          lit[0] = 1'b1;
          next_chase();
        end
      end
      case (show_phase)
        SHOW_CHASE:             want.stage = STG_CHASE;
        SHOW_BLINK, SHOW_END:   want.stage = STG_BLINK;
        SHOW_DONE:              want.stage = STG_DONE;
        default:                want.stage = STG_IDLE;
      endcase
      want.mask = lit;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at result %0d: %s", checked, what);
    endtask

    task check_result(logic [LED_MASK_W-1:0] mask, logic [STAGE_W-1:0] stage);
      led_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result mask %h stage %0d", mask, stage));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (mask !== want.mask) begin
        report_mismatch($sformatf("led_mask %h, expected %h", mask, want.mask));
      end
      if (stage !== want.stage) begin
        report_mismatch($sformatf("show_stage %0d, expected %0d", stage, want.stage));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and block inputs
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_LED_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  s_valid     = 1'b0;
  logic [S_TDATA_W-1:0]  s_tdata     = '0;
  logic                  s_tuser     = OP_TICK;
  logic                  m_ready     = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  led_show_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_cycles   = 0;
  int unsigned items_sent     = 0;
  int unsigned shows_started  = 0;
  int unsigned reg_writes     = 0;

  always #1 clk_i = ~clk_i;

  led_chase_then_blink_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Receiver: random stalls plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      sb.check_result(m_axis_tdata[LED_MASK_W-1:0],
                      m_axis_tdata[LED_MASK_W +: STAGE_W]);
    end
  end

  // Watchdog: ends the run when no item moves for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it; valid stays high
  task automatic send_item(logic op, logic [DUR_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, dur};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, dur);
    items_sent++;
    if (op == OP_START) shows_started++;
  endtask

  task automatic send_ticks(int unsigned count);
    repeat (count) send_item(OP_TICK, DUR_W'($urandom));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    reg_writes++;
  endtask

  // Write all registers plus the unmapped index; block must be idle
  task automatic configure(int unsigned leds, int unsigned chase, int unsigned blink);
    cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_write(REG_LED_COUNT, CFG_DATA_W'(leds));
    cfg_write(REG_CHASE_STEP, CFG_DATA_W'(chase));
    cfg_write(REG_BLINK_HALF, CFG_DATA_W'(blink));
    cfg_we <= 1'b0;
  endtask

  // Mostly short shows so that they run through every phase
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(9))
      0:       return DUR_W'($urandom);
      1, 2:    return DUR_W'($urandom_range(2000));
      default: return DUR_W'($urandom_range(150));
    endcase
  endfunction

  function automatic int unsigned pick_period();
    return ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(15);
  endfunction

  // Shows with random content, with some stray items mixed in
  task automatic run_shows(int unsigned budget);
    int unsigned left;
    int unsigned ticks;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        send_item(logic'($urandom_range(1)), DUR_W'($urandom));
        left--;
      end else begin
        send_item(OP_START, pick_duration());
        left--;
        ticks = $urandom_range(70);
        while (ticks > 0 && left > 0) begin
          send_item(OP_TICK, DUR_W'($urandom));
          ticks--;
          left--;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    int unsigned leds;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chase over four LEDs, stopped with the lit LED at position 3
    configure(4, 2, 3);
    send_item(OP_START, DUR_W'(40));
    send_ticks(7);
    // count lowered below the lit LED: it goes dark and the position wraps
    drain();
    configure(2, 2, 3);
    send_ticks(3);
    // count zero mid-chase, then a start that cancels the show
    drain();
    configure(0, 2, 3);
    send_ticks(2);
    send_item(OP_START, DUR_W'(100));
    send_ticks(1);
    // zero periods, oversized count, shortest and longest shows
    drain();
    configure(31, 0, 0);
    send_item(OP_START, '0);
    send_ticks(2);
    send_item(OP_START, '1);
    send_ticks(2);

    // Random part over four pacing profiles
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int r = 0; r < 4; r++) begin
        drain();
        if (r == 0) begin
          case (p)
            0:       configure(16, 1, 1);
            1:       configure(1, 65535, 65535);
            2:       configure(9, 65535, 0);
            default: configure(3, 0, 65535);
          endcase
        end else begin
          leds = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
          configure(leds, pick_period(), pick_period());
        end
        // output held off while input keeps coming: queue fills, input stalls
        if (p == 0 && r == 1) hold_reqs++;
        run_shows(ROUND_ITEMS);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d items (%0d show starts), %0d results checked, %0d register writes,",
             items_sent, shows_started, sb.checked, reg_writes);
    $display("across four pacing profiles and one long output hold-off.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
